// ===== rtl/csi_pkg.sv =====
`timescale 1ns / 1ps
package csi_pkg;

	localparam int DUTY_BITS     = 12;
	localparam int AXIS_COUNT    = 4;
	localparam int BICEP_AXIS    = (AXIS_COUNT > 1) ? 1 : 0;
	localparam int DATA_BITS     = ((AXIS_COUNT * DUTY_BITS + 7) / 8) * 8;
	localparam int STEP_CNT_BITS = $clog2(DUTY_BITS);
	localparam int ADDR_BITS     = 3;
	localparam int APB_BITS      = 32;

	typedef logic [DUTY_BITS-1:0] duty_t;

	typedef struct packed {
		logic load;
		logic run;
	} lane_ctrl_t;

	function automatic duty_t home_duty(input int axis);
		duty_t d;
		unique case (axis)
			0:       d = duty_t'(105);
			1:       d = duty_t'(338);
			2:       d = duty_t'(500);
			3:       d = duty_t'(500);
			default: d = '0;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/coordinated_servo_interpolator.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata targets, tuser mode
// m_*       out  m_tvalid/m_tready  tdata duties, tuser status, tlast last step
// apb       in   psel/penable       bicep bounds at 0x0 and 0x4
//
// a tick during a move runs through the bit-serial multiply-divide in each axis lane,
// all axes in parallel
// a load passes through S_EVAL to S_OUT, an idle tick goes straight to S_OUT
// reset restores home positions and default bounds, no move in progress
// the result sits in an output register; a new item is taken while it waits,
// and a finished result waits in the output stage while m_tready is low
module coordinated_servo_interpolator import csi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [DATA_BITS-1:0] s_tdata,  // target_shoulder, target_bicep, target_forearm, target_hand
	input  logic [0:0]           s_tuser,  // mode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [DATA_BITS-1:0] m_tdata,  // shoulder_duty, bicep_duty, forearm_duty, hand_duty
	output logic [2:0]           m_tuser,  // status
	output logic                 m_tlast,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [APB_BITS-1:0]  pwdata,
	output logic [APB_BITS-1:0]  prdata,
	output logic                 pready
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_RUN  = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	localparam logic [2:0] STAT_IDLE   = 3'd0;
	localparam logic [2:0] STAT_STEP   = 3'd1;
	localparam logic [2:0] STAT_ACCEPT = 3'd2;
	localparam logic [2:0] STAT_REJECT = 3'd3;
	localparam logic [2:0] STAT_NOMOVE = 3'd4;

	localparam logic MODE_LOAD = 1'b0;

	typedef logic [AXIS_COUNT-1:0][DUTY_BITS-1:0] axes_t;

	logic [2:0]               state_q;
	axes_t                    start_q;
	axes_t                    goal_q;
	axes_t                    tgt_q;
	duty_t                    step_index_q;
	duty_t                    step_total_q;
	logic                     moving_q;
	logic [STEP_CNT_BITS-1:0] cnt_q;
	axes_t                    res_duty_q;
	logic [2:0]               res_status_q;
	logic                     res_last_q;
	axes_t                    out_duty_q;
	logic [2:0]               out_status_q;
	logic                     out_last_q;
	logic                     out_valid_q;

	duty_t      lower_bound;
	duty_t      upper_bound;
	axes_t      tgt_in;
	axes_t      lane_duty;
	lane_ctrl_t lane_ctrl;
	logic       in_acc;
	logic       out_load;
	logic       reject;
	duty_t      most;
	duty_t      diff;

	csi_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.lower_bound (lower_bound),
		.upper_bound (upper_bound)
	);

	assign s_tready = state_q == S_IDLE;
	assign in_acc   = s_tvalid & s_tready;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || m_tready);

	always_comb begin
		for (int a = 0; a < AXIS_COUNT; a++) begin
			tgt_in[a] = s_tdata[a*DUTY_BITS +: DUTY_BITS];
		end
	end

	assign lane_ctrl.load = in_acc && (s_tuser[0] != MODE_LOAD) && moving_q;
	assign lane_ctrl.run  = state_q == S_RUN;

	for (genvar g = 0; g < AXIS_COUNT; g++) begin : g_lane
		csi_lane u_lane (
			.clk   (clk),
			.ctrl  (lane_ctrl),
			.start (start_q[g]),
			.goal  (goal_q[g]),
			.step  (step_index_q),
			.total (step_total_q),
			.duty  (lane_duty[g])
		);
	end

	// largest absolute delta of a load
	always_comb begin
		most = '0;
		diff = '0;
		for (int a = 0; a < AXIS_COUNT; a++) begin
			diff = (tgt_q[a] >= start_q[a]) ? tgt_q[a] - start_q[a] : start_q[a] - tgt_q[a];
			if (diff > most) begin
				most = diff;
			end
		end
	end

	assign reject = moving_q || (tgt_q[BICEP_AXIS] < lower_bound)
	                || (tgt_q[BICEP_AXIS] > upper_bound);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_index_q <= '0;
			step_total_q <= '0;
			moving_q     <= 1'b0;
			cnt_q        <= '0;
			for (int a = 0; a < AXIS_COUNT; a++) begin
				start_q[a] <= home_duty(a);
				goal_q[a]  <= home_duty(a);
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cnt_q <= '0;
						priority if (s_tuser[0] == MODE_LOAD) begin
							state_q <= S_EVAL;
						end else if (moving_q) begin
							state_q <= S_RUN;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_EVAL: begin
					if (!reject && most != '0) begin
						goal_q       <= tgt_q;
						step_index_q <= '0;
						step_total_q <= most;
						moving_q     <= 1'b1;
					end
					state_q <= S_OUT;
				end
				S_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_CNT_BITS'(DUTY_BITS - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (step_index_q >= step_total_q) begin
						start_q      <= goal_q;
						step_index_q <= '0;
						step_total_q <= '0;
						moving_q     <= 1'b0;
					end else begin
						step_index_q <= step_index_q + 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result staging, payload only
	always_ff @(posedge clk) begin
		if (in_acc) begin
			tgt_q        <= tgt_in;
			res_duty_q   <= start_q;
			res_status_q <= STAT_IDLE;
			res_last_q   <= 1'b0;
		end
		if (state_q == S_EVAL) begin
			res_duty_q <= start_q;
			res_last_q <= 1'b0;
			priority if (reject) begin
				res_status_q <= STAT_REJECT;
			end else if (most == '0) begin
				res_status_q <= STAT_NOMOVE;
			end else begin
				res_status_q <= STAT_ACCEPT;
			end
		end
		if (state_q == S_FIN) begin
			res_duty_q   <= lane_duty;
			res_status_q <= STAT_STEP;
			res_last_q   <= step_index_q >= step_total_q;
		end
		if (out_load) begin
			out_duty_q   <= res_duty_q;
			out_status_q <= res_status_q;
			out_last_q   <= res_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = DATA_BITS'(out_duty_q);
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== rtl/csi_regs.sv =====
`timescale 1ns / 1ps
module csi_regs import csi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [APB_BITS-1:0]  pwdata,
	output logic [APB_BITS-1:0]  prdata,
	output logic                 pready,
	output duty_t                lower_bound,
	output duty_t                upper_bound
);

	localparam logic REG_LOWER = 1'b0;
	localparam logic REG_UPPER = 1'b1;

	duty_t lower_q;
	duty_t upper_q;
	logic  wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= duty_t'(299);
			upper_q <= duty_t'(460);
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_LOWER: lower_q <= pwdata[DUTY_BITS-1:0];
				REG_UPPER: upper_q <= pwdata[DUTY_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_LOWER: prdata = APB_BITS'(lower_q);
			REG_UPPER: prdata = APB_BITS'(upper_q);
		endcase
	end

	assign lower_bound = lower_q;
	assign upper_bound = upper_q;

endmodule

// ===== rtl/csi_lane.sv =====
`timescale 1ns / 1ps
module csi_lane import csi_pkg::*; (
	input  logic       clk,
	input  lane_ctrl_t ctrl,
	input  duty_t      start,
	input  duty_t      goal,
	input  duty_t      step,
	input  duty_t      total,
	output duty_t      duty
);

	localparam int TW = DUTY_BITS + 2;

	duty_t start_q;
	duty_t mag_q;
	logic  neg_q;
	duty_t step_sh_q;
	duty_t rem_q;
	duty_t quo_q;

	logic [TW-1:0] t;
	logic [TW-1:0] t_rem;
	logic [TW-1:0] n_ext;
	logic [TW-1:0] two_n;
	logic [1:0]    digit;

	// one step bit a cycle: remainder doubles, adds |delta| when the bit is set,
	// quotient digit 0..2 since remainder < N and |delta| <= N
	always_comb begin
		n_ext = {2'b00, total};
		two_n = {1'b0, total, 1'b0};
		t     = {1'b0, rem_q, 1'b0} + (step_sh_q[DUTY_BITS-1] ? {2'b00, mag_q} : '0);
		priority if (t >= two_n) begin
			t_rem = t - two_n;
			digit = 2'd2;
		end else if (t >= n_ext) begin
			t_rem = t - n_ext;
			digit = 2'd1;
		end else begin
			t_rem = t;
			digit = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			start_q   <= start;
			mag_q     <= (goal >= start) ? goal - start : start - goal;
			neg_q     <= goal < start;
			step_sh_q <= step;
			rem_q     <= '0;
			quo_q     <= '0;
		end else if (ctrl.run) begin
			step_sh_q <= {step_sh_q[DUTY_BITS-2:0], 1'b0};
			rem_q     <= t_rem[DUTY_BITS-1:0];
			quo_q     <= {quo_q[DUTY_BITS-2:0], 1'b0} + duty_t'(digit);
		end
	end

	assign duty = neg_q ? start_q - quo_q : start_q + quo_q;

endmodule

// ===== dv/tb_coordinated_servo_interpolator.sv =====
`timescale 1ns / 1ps
module tb_coordinated_servo_interpolator;
	import csi_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_STEP   = 3'd1,
		ST_ACCEPT = 3'd2,
		ST_REJECT = 3'd3,
		ST_NOMOVE = 3'd4
	} servo_status_e;

	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_TICK = 1'b1
	} servo_mode_e;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;
	typedef enum int {BND_HOME, BND_FULL, BND_INVERTED, BND_PINNED, BND_WINDOW} bound_set_e;

	localparam int REG_BICEP_LO = 0;
	localparam int REG_BICEP_HI = 1;
	localparam int HOME_LO      = 299;
	localparam int HOME_HI      = 460;
	localparam int DUTY_MAX     = (1 << DUTY_BITS) - 1;
	localparam int QUIET_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 40;

	typedef struct {
		duty_t         duty[AXIS_COUNT];
		servo_status_e status;
		logic          last;
	} servo_out_t;

	typedef struct {
		servo_mode_e mode;
		duty_t       tgt[AXIS_COUNT];
		bit          fixed;
		servo_out_t  want;
	} directed_row_t;

	typedef struct {
		bound_set_e bounds;
		int         budget;
		idle_e      idle;
	} phase_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [DATA_BITS-1:0] s_tdata  = '0;
	logic [0:0]           s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [DATA_BITS-1:0] m_tdata;
	logic [2:0]           m_tuser;
	logic                 m_tlast;
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [ADDR_BITS-1:0] paddr    = '0;
	logic [APB_BITS-1:0]  pwdata   = '0;
	logic [APB_BITS-1:0]  prdata;
	logic                 pready;

	// predicted block state
	duty_t pos_start[AXIS_COUNT] = '{105, 338, 500, 500};
	duty_t pos_goal[AXIS_COUNT]  = '{105, 338, 500, 500};
	int    step_at     = 0;
	int    step_span   = 0;
	bit    in_motion   = 1'b0;
	int    bound_lo    = HOME_LO;
	int    bound_hi    = HOME_HI;

	servo_out_t pending_duties[$];
	int         mismatch_count = 0;
	int         quiet_cycles   = 0;
	int         send_idle_pct  = 0;
	int         recv_stall_pct = 0;
	int         wide_left      = 1;
	bit         hold_req       = 1'b0;

	directed_row_t directed_rows[19];
	phase_t        phases[6];

	coordinated_servo_interpolator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic servo_out_t interpolate_servo(input servo_mode_e mode,
			input duty_t tgt[AXIS_COUNT]);
		servo_out_t r;
		int         span;
		int         d;
		longint     off;
		r.duty   = pos_start;
		r.last   = 1'b0;
		r.status = ST_IDLE;
		if (mode == MODE_LOAD) begin
			if (in_motion || int'(tgt[BICEP_AXIS]) < bound_lo ||
					int'(tgt[BICEP_AXIS]) > bound_hi) begin
				r.status = ST_REJECT;
			end else begin
				span = 0;
				for (int a = 0; a < AXIS_COUNT; a++) begin
					d = int'(tgt[a]) - int'(pos_start[a]);
					if (d < 0) d = -d;
					if (d > span) span = d;
				end
				if (span == 0) begin
					r.status = ST_NOMOVE;
				end else begin
					pos_goal  = tgt;
					step_at   = 0;
					step_span = span;
					in_motion = 1'b1;
					r.status  = ST_ACCEPT;
				end
			end
		end else if (in_motion) begin
			for (int a = 0; a < AXIS_COUNT; a++) begin
				off = 0;
				if (step_span != 0)
					off = (longint'(int'(pos_goal[a]) - int'(pos_start[a])) * step_at) / step_span;
				r.duty[a] = duty_t'(longint'(pos_start[a]) + off);
			end
			r.status = ST_STEP;
			if (step_at >= step_span) begin
				r.last    = 1'b1;
				pos_start = pos_goal;
				step_at   = 0;
				step_span = 0;
				in_motion = 1'b0;
			end else begin
				step_at++;
			end
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	function automatic duty_t jitter(input duty_t centre, input int reach, input int lo,
			input int hi);
		int v;
		v = int'(centre) + int'($urandom_range(2 * reach)) - reach;
		if (v < lo) v = lo;
		if (v > hi) v = hi;
		return duty_t'(v);
	endfunction

	task automatic send_item(input servo_mode_e mode, input duty_t tgt[AXIS_COUNT],
			input bit fixed, input servo_out_t want);
		logic [DATA_BITS-1:0] word;
		servo_out_t           predicted;
		word = '0;
		for (int a = 0; a < AXIS_COUNT; a++)
			word[a*DUTY_BITS +: DUTY_BITS] = tgt[a];
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = interpolate_servo(mode, tgt);
		pending_duties.push_back(fixed ? want : predicted);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_duties.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(input int addr, input int data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_BITS'(addr);
		pwdata  <= APB_BITS'(data);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(input int addr, output logic [APB_BITS-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_BITS'(addr);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic pick_random_item(output servo_mode_e mode, output duty_t tgt[AXIS_COUNT]);
		int r;
		int reach;
		for (int a = 0; a < AXIS_COUNT; a++)
			tgt[a] = duty_t'($urandom_range(DUTY_MAX));
		mode = MODE_LOAD;
		if (in_motion) begin
			// mostly ticks, now and then a load that must bounce
			if ($urandom_range(9) != 0) mode = MODE_TICK;
		end else begin
			r = $urandom_range(99);
			if (r < 68) begin
				reach = ($urandom_range(4) == 0) ? 60 : 8;
				for (int a = 0; a < AXIS_COUNT; a++)
					tgt[a] = jitter(pos_start[a], reach, 0, DUTY_MAX);
				if (bound_lo <= bound_hi)
					tgt[BICEP_AXIS] = jitter(pos_start[BICEP_AXIS], reach, bound_lo, bound_hi);
			end else if (r < 78) begin
				mode = MODE_TICK;
			end else if (r < 86) begin
				tgt = pos_start;
			end else if (r < 98 || wide_left == 0 || bound_lo != 0 || bound_hi != DUTY_MAX) begin
				if (bound_lo > 0 && (bound_hi >= DUTY_MAX || $urandom_range(1) == 0))
					tgt[BICEP_AXIS] = duty_t'($urandom_range(bound_lo - 1));
				else if (bound_hi < DUTY_MAX)
					tgt[BICEP_AXIS] = duty_t'($urandom_range(DUTY_MAX, bound_hi + 1));
				else
					mode = MODE_TICK;
			end else begin
				// wider move, a few hundred steps
				for (int a = 0; a < AXIS_COUNT; a++)
					tgt[a] = jitter(pos_start[a], 300, 0, DUTY_MAX);
				wide_left--;
			end
		end
	endtask

	always @(posedge clk) begin
		servo_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_duties.size() == 0) begin
				$display("%0t unexpected item status %0d", $time, m_tuser);
				mismatch_count++;
			end else begin
				want = pending_duties.pop_front();
				for (int a = 0; a < AXIS_COUNT; a++)
					check_field($sformatf("axis %0d duty", a), int'(want.duty[a]),
						int'(m_tdata[a*DUTY_BITS +: DUTY_BITS]));
				check_field("status", int'(want.status), int'(m_tuser));
				check_field("last step", int'(want.last), int'(m_tlast));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_coordinated_servo_interpolator failed");
			$finish;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		servo_mode_e         mode;
		duty_t               tgt[AXIS_COUNT];
		servo_out_t          blank;
		int                  sent;
		int                  lo;
		int                  hi;
		logic [APB_BITS-1:0] readback;

		blank = '{'{0, 0, 0, 0}, ST_IDLE, 1'b0};
		// rows with fixed = 0 are checked against the predictor only
		directed_rows = '{
			'{MODE_TICK, '{0, 0, 0, 0}, 1'b1, '{'{105, 338, 500, 500}, ST_IDLE, 1'b0}},
			'{MODE_TICK, '{4095, 4095, 4095, 4095}, 1'b1,
				'{'{105, 338, 500, 500}, ST_IDLE, 1'b0}},
			'{MODE_LOAD, '{4095, 4095, 4095, 4095}, 1'b1,
				'{'{105, 338, 500, 500}, ST_REJECT, 1'b0}},
			'{MODE_LOAD, '{0, 298, 0, 0}, 1'b1, '{'{105, 338, 500, 500}, ST_REJECT, 1'b0}},
			'{MODE_LOAD, '{4095, 461, 4095, 0}, 1'b1,
				'{'{105, 338, 500, 500}, ST_REJECT, 1'b0}},
			'{MODE_LOAD, '{105, 338, 500, 500}, 1'b1,
				'{'{105, 338, 500, 500}, ST_NOMOVE, 1'b0}},
			'{MODE_LOAD, '{108, 340, 497, 500}, 1'b1,
				'{'{105, 338, 500, 500}, ST_ACCEPT, 1'b0}},
			'{MODE_LOAD, '{0, 0, 0, 0}, 1'b1, '{'{105, 338, 500, 500}, ST_REJECT, 1'b0}},
			'{MODE_TICK, '{0, 0, 0, 0}, 1'b0, blank},
			'{MODE_LOAD, '{108, 340, 497, 500}, 1'b1,
				'{'{105, 338, 500, 500}, ST_REJECT, 1'b0}},
			'{MODE_TICK, '{4095, 0, 4095, 0}, 1'b0, blank},
			'{MODE_TICK, '{0, 4095, 0, 4095}, 1'b0, blank},
			'{MODE_TICK, '{0, 0, 0, 0}, 1'b0, blank},
			'{MODE_TICK, '{0, 0, 0, 0}, 1'b1, '{'{108, 340, 497, 500}, ST_IDLE, 1'b0}},
			'{MODE_LOAD, '{108, 340, 497, 500}, 1'b1,
				'{'{108, 340, 497, 500}, ST_NOMOVE, 1'b0}},
			'{MODE_LOAD, '{106, 342, 499, 503}, 1'b1,
				'{'{108, 340, 497, 500}, ST_ACCEPT, 1'b0}},
			'{MODE_TICK, '{0, 0, 0, 0}, 1'b0, blank},
			'{MODE_TICK, '{0, 0, 0, 0}, 1'b0, blank},
			'{MODE_TICK, '{0, 0, 0, 0}, 1'b0, blank}
		};
		phases = '{
			'{BND_HOME,     300, IDLE_NONE},
			'{BND_FULL,     250, IDLE_SEND},
			'{BND_INVERTED,  60, IDLE_RECV},
			'{BND_PINNED,   150, IDLE_BOTH},
			'{BND_WINDOW,   300, IDLE_NONE},
			'{BND_FULL,     240, IDLE_BOTH}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].mode, directed_rows[i].tgt, directed_rows[i].fixed,
				directed_rows[i].want);
		// last tick of the second move still pending
		send_item(MODE_TICK, '{0, 0, 0, 0}, 1'b0, blank);
		drain_results();

		foreach (phases[p]) begin
			case (phases[p].bounds)
				BND_HOME: begin
					lo = HOME_LO;
					hi = HOME_HI;
				end
				BND_FULL: begin
					lo = 0;
					hi = DUTY_MAX;
				end
				BND_INVERTED: begin
					lo = DUTY_MAX;
					hi = 0;
				end
				BND_PINNED: begin
					lo = int'(pos_start[BICEP_AXIS]);
					hi = lo;
				end
				default: begin
					lo = (int'(pos_start[BICEP_AXIS]) > 40) ? int'(pos_start[BICEP_AXIS]) - 40 : 0;
					hi = (int'(pos_start[BICEP_AXIS]) < DUTY_MAX - 40) ?
						int'(pos_start[BICEP_AXIS]) + 40 : DUTY_MAX;
				end
			endcase
			apb_write(REG_BICEP_LO * 4, lo);
			apb_write(REG_BICEP_HI * 4, hi);
			bound_lo = lo;
			bound_hi = hi;
			apb_read(REG_BICEP_LO * 4, readback);
			check_field("lower bound readback", lo, int'(readback));
			apb_read(REG_BICEP_HI * 4, readback);
			check_field("upper bound readback", hi, int'(readback));

			send_idle_pct  = (phases[p].idle == IDLE_SEND) ? 79 :
				(phases[p].idle == IDLE_BOTH) ? 17 : 0;
			recv_stall_pct = (phases[p].idle == IDLE_RECV) ? 79 :
				(phases[p].idle == IDLE_BOTH) ? 17 : 0;
			// long output stall while the input keeps offering
			if (p == 0) hold_req = 1'b1;

			sent = 0;
			while (sent < phases[p].budget || in_motion) begin
				if (p == 5 && sent == phases[p].budget / 2) drain_results();
				pick_random_item(mode, tgt);
				send_item(mode, tgt, 1'b0, blank);
				sent++;
			end
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_coordinated_servo_interpolator passed");
		else
			$display("tb_coordinated_servo_interpolator failed");
		$finish;
	end

endmodule
